>>> design/assert_macros.svh
// Assertion macros used by the equalizer section cell.
// Simulation builds get concurrent checks; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
`define ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop, msg)
`define ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif
`endif

>>> design/tbeq_pkg.sv
`timescale 1ns / 1ps
// Package for the three-band equalizer: widths, register codes, types.
// No dependencies; used by tbeq_regs, tbeq_section and the top level.
package tbeq_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 26;

    localparam int COEF_BITS      = 32;
    localparam int REG_BITS       = 64;
    localparam int NUM_REGS       = 8;
    localparam int REG_IDX_BITS   = $clog2(NUM_REGS);
    localparam int ADDR_LSB       = 3;
    localparam int PADDR_BITS     = REG_IDX_BITS + ADDR_LSB;
    localparam int TAPS           = 5;
    localparam int NUM_SECTIONS   = 3;
    localparam int NUM_COEFS      = TAPS * NUM_SECTIONS;
    localparam int ACC_GUARD_BITS = 3;
    localparam int STEP_BITS      = $clog2(TAPS + 1);

    // MAC step codes: one product per step, then a drain step
    localparam logic [STEP_BITS-1:0] TAP_B0    = STEP_BITS'(0);
    localparam logic [STEP_BITS-1:0] TAP_B1    = STEP_BITS'(1);
    localparam logic [STEP_BITS-1:0] TAP_B2    = STEP_BITS'(2);
    localparam logic [STEP_BITS-1:0] TAP_A1    = STEP_BITS'(3);
    localparam logic [STEP_BITS-1:0] TAP_A2    = STEP_BITS'(4);
    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(TAPS);

    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef coef_t [TAPS-1:0]            sec_coefs_t;
    typedef coef_t [NUM_COEFS-1:0]       all_coefs_t;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_LOW_B0_B1     = 3'd0,
        REG_LOW_B2_A1     = 3'd1,
        REG_LOW_A2_MID_B0 = 3'd2,
        REG_MID_B1_B2     = 3'd3,
        REG_MID_A1_A2     = 3'd4,
        REG_HIGH_B0_B1    = 3'd5,
        REG_HIGH_B2_A1    = 3'd6,
        REG_HIGH_A2       = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        SEC_IDLE,
        SEC_MAC,
        SEC_ROUND
    } sec_state_t;

endpackage

>>> design/three_band_biquad_equalizer_core.sv
`timescale 1ns / 1ps
// Top level of the three-band equalizer: register file and a chain of three biquad cells.
// Depends on tbeq_pkg, tbeq_regs and tbeq_section.
//
// Usage:
//   Input channel in_valid / in_ready / sample_in carries one signed sample per item;
//   output channel out_valid / out_ready / sample_out / clipped returns one result per
//   item, in order. clipped is set when any of the three sections saturated.
//   Coefficients are written through the APB-style port (64-bit data, register i at
//   byte address 8*i; pready is always high). Write them only while the block is idle.
// Timing:
//   Each section runs one multiplier over its five products, then rounds and
//   saturates. The three sections work on successive items at once, but each
//   section accepts a new item only after it has finished the previous one.
// Reset:
//   Clears all twelve history words and loads unity low/high b0 and mid b0 with
//   all other coefficients zero, so samples pass through unchanged.
// Back-pressure:
//   While out_ready is low the last section holds its result; the earlier sections
//   finish their current items and then hold too, and in_ready drops.
module three_band_biquad_equalizer_core
    import tbeq_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_BITS-1:0]         paddr,
    input  logic [REG_BITS-1:0]           pwdata,
    output logic [REG_BITS-1:0]           prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          clipped
);

    all_coefs_t coefs;

    // Link k feeds section k; the last link is the block output
    logic                          link_valid  [NUM_SECTIONS+1];
    logic                          link_ready  [NUM_SECTIONS+1];
    logic signed [SAMPLE_BITS-1:0] link_sample [NUM_SECTIONS+1];
    logic                          link_clip   [NUM_SECTIONS+1];

    tbeq_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    assign link_valid[0]  = in_valid;
    assign in_ready       = link_ready[0];
    assign link_sample[0] = sample_in;
    assign link_clip[0]   = 1'b0;

    // Low shelf, mid peak, high shelf in that order
    for (genvar g = 0; g < NUM_SECTIONS; g++)
    begin : g_section
        tbeq_section #(
            .SAMPLE_BITS    (SAMPLE_BITS),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_section (
            .clk        (clk),
            .rst_n      (rst_n),
            .coefs      (coefs[TAPS*g +: TAPS]),
            .in_valid   (link_valid[g]),
            .in_ready   (link_ready[g]),
            .in_sample  (link_sample[g]),
            .in_clip    (link_clip[g]),
            .out_valid  (link_valid[g+1]),
            .out_ready  (link_ready[g+1]),
            .out_sample (link_sample[g+1]),
            .out_clip   (link_clip[g+1])
        );
    end

    assign out_valid              = link_valid[NUM_SECTIONS];
    assign link_ready[NUM_SECTIONS] = out_ready;
    assign sample_out             = link_sample[NUM_SECTIONS];
    assign clipped                = link_clip[NUM_SECTIONS];

endmodule

>>> design/tbeq_regs.sv
`timescale 1ns / 1ps
// APB-style coefficient register file for the equalizer.
// Depends on tbeq_pkg; unpacks eight registers into fifteen coefficients.
module tbeq_regs
    import tbeq_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [REG_BITS-1:0]   pwdata,
    output logic [REG_BITS-1:0]   prdata,
    output logic                  pready,
    output all_coefs_t            coefs
);

    localparam logic [REG_BITS-1:0] UNIT_HI = REG_BITS'(1) << (COEF_BITS + COEF_FRAC_BITS);
    localparam logic [REG_BITS-1:0] UNIT_LO = REG_BITS'(1) << COEF_FRAC_BITS;
    localparam logic [REG_BITS-1:0] ZERO    = '0;
    localparam logic [REG_BITS-1:0] RESET_VAL [NUM_REGS] =
        '{UNIT_HI, ZERO, UNIT_LO, ZERO, ZERO, UNIT_HI, ZERO, ZERO};

    logic [REG_BITS-1:0] cfg_reg  [NUM_REGS];
    logic [REG_BITS-1:0] cfg_next [NUM_REGS];
    logic                wr_en;
    reg_idx_t            addr_idx;

    assign wr_en    = psel && penable && pwrite;
    assign addr_idx = reg_idx_t'(paddr[PADDR_BITS-1:ADDR_LSB]);
    assign pready   = 1'b1;
    assign prdata   = cfg_reg[addr_idx];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (addr_idx)
                REG_HIGH_A2:
                begin
                    // single 32-bit register: drop the upper word
                    cfg_next[addr_idx] = {{(REG_BITS-COEF_BITS){1'b0}}, pwdata[COEF_BITS-1:0]};
                end
                default:
                begin
                    cfg_next[addr_idx] = pwdata;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= RESET_VAL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Upper half first, lower half second; the last register holds one coefficient
    for (genvar k = 0; k < NUM_COEFS; k++)
    begin : g_unpack
        if (k == NUM_COEFS - 1)
        begin : g_single
            assign coefs[k] = cfg_reg[k/2][COEF_BITS-1:0];
        end
        else if (k % 2 == 0)
        begin : g_upper
            assign coefs[k] = cfg_reg[k/2][REG_BITS-1:COEF_BITS];
        end
        else
        begin : g_lower
            assign coefs[k] = cfg_reg[k/2][COEF_BITS-1:0];
        end
    end

endmodule

>>> design/tbeq_section.sv
`timescale 1ns / 1ps
// One direct-form-I biquad cell: own history, one serial multiplier, output register.
// Depends on tbeq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tbeq_section
    import tbeq_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sec_coefs_t                    coefs,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_clip,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic                          out_clip
);

    localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS  = PROD_BITS + ACC_GUARD_BITS;
    localparam int QUOT_BITS = ACC_BITS - COEF_FRAC_BITS;
    localparam int HI_BITS   = QUOT_BITS - SAMPLE_BITS + 1;
    localparam logic signed [ACC_BITS-1:0] ACC_HALF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    sec_state_t                    state_reg, state_next;
    logic [STEP_BITS-1:0]          step_reg, step_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic signed [SAMPLE_BITS-1:0] x1_reg, x1_next, x2_reg, x2_next;
    logic signed [SAMPLE_BITS-1:0] y1_reg, y1_next, y2_reg, y2_next;
    logic                          clip_reg, clip_next;
    logic signed [PROD_BITS-1:0]   prod_reg, prod_next;
    logic                          sub_reg, sub_next;
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic                          out_clip_reg, out_clip_next;

    coef_t                         coef_sel;
    logic signed [SAMPLE_BITS-1:0] opnd_sel;
    logic                          sub_sel;
    logic signed [ACC_BITS-1:0]    prod_ext;
    logic signed [QUOT_BITS-1:0]   quot;
    logic [HI_BITS-1:0]            quot_hi;
    logic                          fits;
    logic signed [SAMPLE_BITS-1:0] sat_sample;
    logic                          out_free;

    assign in_ready   = (state_reg == SEC_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_clip   = out_clip_reg;
    assign out_free   = !out_valid_reg || out_ready;

    // Operand select per step; feedback taps subtract
    always_comb
    begin
        case (step_reg)
            TAP_B0:
            begin
                coef_sel = coefs[0];
                opnd_sel = x_reg;
                sub_sel  = 1'b0;
            end
            TAP_B1:
            begin
                coef_sel = coefs[1];
                opnd_sel = x1_reg;
                sub_sel  = 1'b0;
            end
            TAP_B2:
            begin
                coef_sel = coefs[2];
                opnd_sel = x2_reg;
                sub_sel  = 1'b0;
            end
            TAP_A1:
            begin
                coef_sel = coefs[3];
                opnd_sel = y1_reg;
                sub_sel  = 1'b1;
            end
            TAP_A2:
            begin
                coef_sel = coefs[4];
                opnd_sel = y2_reg;
                sub_sel  = 1'b1;
            end
            default:
            begin
                coef_sel = '0;
                opnd_sel = '0;
                sub_sel  = 1'b0;
            end
        endcase
    end

    // Round: half LSB was preloaded, so a floor shift completes it
    assign prod_ext   = ACC_BITS'(prod_reg);
    assign quot       = acc_reg[ACC_BITS-1:COEF_FRAC_BITS];
    assign quot_hi    = quot[QUOT_BITS-1:SAMPLE_BITS-1];
    assign fits       = (&quot_hi) || !(|quot_hi);
    assign sat_sample = fits ? quot[SAMPLE_BITS-1:0]
                             : (quot[QUOT_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX);

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        x_next          = x_reg;
        x1_next         = x1_reg;
        x2_next         = x2_reg;
        y1_next         = y1_reg;
        y2_next         = y2_reg;
        clip_next       = clip_reg;
        acc_next        = acc_reg;
        // 32 x SAMPLE_BITS product, sized by the destination
        prod_next       = coef_sel * opnd_sel;
        sub_next        = sub_sel;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_clip_next   = out_clip_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            SEC_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = in_sample;
                    clip_next  = in_clip;
                    acc_next   = ACC_HALF;
                    step_next  = TAP_B0;
                    state_next = SEC_MAC;
                end
            end
            SEC_MAC:
            begin
                // accumulate the product issued one step earlier
                if (step_reg != TAP_B0)
                begin
                    acc_next = sub_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
                end
                if (step_reg == STEP_LAST)
                begin
                    state_next = SEC_ROUND;
                end
                else
                begin
                    step_next = step_reg + STEP_BITS'(1);
                end
            end
            SEC_ROUND:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = sat_sample;
                    out_clip_next   = clip_reg || !fits;
                    x2_next         = x1_reg;
                    x1_next         = x_reg;
                    y2_next         = y1_reg;
                    y1_next         = sat_sample;
                    state_next      = SEC_IDLE;
                end
            end
            default:
            begin
                state_next = SEC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEC_IDLE;
            step_reg      <= TAP_B0;
            x1_reg        <= '0;
            x2_reg        <= '0;
            y1_reg        <= '0;
            y2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            x1_reg        <= x1_next;
            x2_reg        <= x2_next;
            y1_reg        <= y1_next;
            y2_reg        <= y2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        clip_reg       <= clip_next;
        prod_reg       <= prod_next;
        sub_reg        <= sub_next;
        acc_reg        <= acc_next;
        out_sample_reg <= out_sample_next;
        out_clip_reg   <= out_clip_next;
    end

    `ASSERT_NEXT(a_accept_starts_mac, clk, rst_n, in_valid && in_ready, state_reg == SEC_MAC && step_reg == TAP_B0, "accepted item did not start the MAC sequence")
    `ASSERT_SAME(a_step_bound, clk, rst_n, state_reg == SEC_MAC, step_reg <= STEP_LAST, "MAC step ran past the drain step")
    `ASSERT_NEXT(a_round_holds, clk, rst_n, state_reg == SEC_ROUND && out_valid_reg && !out_ready, state_reg == SEC_ROUND, "result left the cell while the output was blocked")
    `ASSERT_NEXT(a_history_update, clk, rst_n, state_reg == SEC_ROUND && out_free, y1_reg == out_sample_reg && x1_reg == $past(x_reg), "history not advanced with the delivered result")

endmodule
